>>> src/lbd_pkg.sv
// ----------------------------------------------------------------------------
// Letterbox border detector package
// Shared widths, register indexes, queue record and sequencer state codes.
// ----------------------------------------------------------------------------
package lbd_pkg;

   localparam int LINE_MAX    = 4096;
   localparam int EXTENT_MAX  = 4096;
   localparam int QUEUE_DEPTH = 4;

   localparam int LUMA_W  = 8;
   localparam int TOL_W   = 8;
   localparam int EXT_W   = 13;
   localparam int IDX_W   = 12;
   localparam int CNT_W   = $clog2(LINE_MAX) + 1;
   localparam int SUM_W   = LUMA_W + $clog2(LINE_MAX);
   localparam int SQ_W    = 2 * LUMA_W + $clog2(LINE_MAX);
   localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W  = QPTR_W + 1;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_EXTENT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISY_REF   = 2'd2;

   localparam logic [TOL_W-1:0] TOL_RESET = 8'd30;
   localparam logic [EXT_W-1:0] EXT_RESET = 13'd480;

   typedef struct packed {
      logic [TOL_W-1:0] tolerance;
      logic [EXT_W-1:0] scan_extent;
      logic             noisy_reference_stops;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic             has_line;
      logic [CNT_W-1:0] n;
      logic [SUM_W-1:0] s;
      logic [SQ_W-1:0]  q;
   } line_rec_type;

   typedef struct packed {
      logic         valid;
      line_rec_type rec;
   } line_push_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MUL   = 7'b0000010,
      ST_SCALE = 7'b0000100,
      ST_CMP   = 7'b0001000,
      ST_DIV   = 7'b0010000,
      ST_DEC   = 7'b0100000,
      ST_OUT   = 7'b1000000
   } back_state_type;

endpackage

>>> src/lbd_if.sv
// ----------------------------------------------------------------------------
// Letterbox border detector channels
// Valid/ready interfaces for the pixel words and the border result words.
// ----------------------------------------------------------------------------
interface lbd_req_if import lbd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [LUMA_W-1:0] luma;
   logic              line_end;
   logic              scan_start;

   modport source (output valid, luma, line_end, scan_start, input ready);
   modport sink   (input valid, luma, line_end, scan_start, output ready);
endinterface

interface lbd_rsp_if import lbd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] border;
   logic             accepted;

   modport source (output valid, border, accepted, input ready);
   modport sink   (input valid, border, accepted, output ready);
endinterface

>>> src/lbd_front.sv
// ----------------------------------------------------------------------------
// Letterbox border detector front end
// Accepts pixel words, accumulates line count, sum and square sum, and
// pushes one record per line end or scan start into the line queue.
// ----------------------------------------------------------------------------
module lbd_front import lbd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   lbd_req_if.sink       req,
   input  logic          q_full,
   output line_push_type push
);

   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_base, cnt_add;
   logic [SUM_W-1:0] sum_ff, sum_in, sum_base, sum_add;
   logic [SQ_W-1:0]  sq_ff, sq_in, sq_base, sq_add;
   logic             accept;

   always_comb begin
      req.ready = !q_full;
      accept    = req.valid && req.ready;
      cnt_base  = req.scan_start ? '0 : cnt_ff;
      sum_base  = req.scan_start ? '0 : sum_ff;
      sq_base   = req.scan_start ? '0 : sq_ff;
      cnt_add   = cnt_base;
      sum_add   = sum_base;
      sq_add    = sq_base;
      // drop pixels beyond the line limit
      if (cnt_base < CNT_W'(LINE_MAX)) begin
         cnt_add = cnt_base + CNT_W'(1);
         sum_add = sum_base + SUM_W'(req.luma);
         sq_add  = sq_base + SQ_W'(req.luma) * SQ_W'(req.luma);
      end
      push.valid        = accept && (req.line_end || req.scan_start);
      push.rec.start    = req.scan_start;
      push.rec.has_line = req.line_end;
      push.rec.n        = cnt_add;
      push.rec.s        = sum_add;
      push.rec.q        = sq_add;
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      sq_in  = sq_ff;
      if (accept) begin
         if (req.line_end) begin
            cnt_in = '0;
            sum_in = '0;
            sq_in  = '0;
         end else begin
            cnt_in = cnt_add;
            sum_in = sum_add;
            sq_in  = sq_add;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sum_ff <= '0;
         sq_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         sum_ff <= sum_in;
         sq_ff  <= sq_in;
      end
   end

endmodule

>>> src/lbd_queue.sv
// ----------------------------------------------------------------------------
// Letterbox border detector line queue
// Short FIFO of line records between the front end and the evaluator.
// ----------------------------------------------------------------------------
module lbd_queue import lbd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  line_push_type push,
   output logic          full,
   input  logic          pop,
   output logic          valid,
   output line_rec_type  rec
);

   line_rec_type      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   always_comb begin
      full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
      valid     = (count_ff != '0);
      rec       = mem_ff[rd_ptr_ff];
      do_push   = push.valid && !full;
      do_pop    = pop && valid;
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> src/lbd_back.sv
// ----------------------------------------------------------------------------
// Letterbox border detector evaluator
// Pops line records, runs the spread and mean tests as registered
// cross-multiplications, divides out the reference mean bit by bit, tracks
// the scan and holds the result word in the output register.
// ----------------------------------------------------------------------------
module lbd_back import lbd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         q_valid,
   input  line_rec_type q_rec,
   output logic         q_pop,
   lbd_rsp_if.source    rsp
);

   localparam int NQ_W  = CNT_W + SQ_W;
   localparam int SS_W  = 2 * SUM_W;
   localparam int TN_W  = TOL_W + CNT_W;
   localparam int TN2_W = 2 * TN_W;
   localparam int RN_W  = LUMA_W + CNT_W;
   localparam int TS_W  = TOL_W + SUM_W;
   localparam int DM_W  = 9 + RN_W;
   localparam int FAR_W = TS_W + 2;
   localparam int NZ_W  = TN2_W + 1;
   localparam int ACC_W = IDX_W + 3;
   localparam int DIV_W = SUM_W;
   localparam int STEP_W = $clog2(LUMA_W);

   back_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [SUM_W-1:0]  s_ff, s_in;
   logic [SQ_W-1:0]   q_ff, q_in;
   logic [NQ_W-1:0]   nq_ff, nq_in;
   logic [SS_W-1:0]   ss_ff, ss_in;
   logic [TN_W-1:0]   tn_ff, tn_in;
   logic [RN_W-1:0]   rn_ff, rn_in;
   logic [TS_W-1:0]   ts_ff, ts_in;
   logic [TN2_W-1:0]  tn2_ff, tn2_in;
   logic [DM_W-1:0]   dm_ff, dm_in;
   logic [RN_W-1:0]   diff;
   logic              noisy_ff, noisy_in, far_ff, far_in;
   logic [DIV_W-1:0]  rem_ff, rem_in, dvs_ff, dvs_in;
   logic [LUMA_W-1:0] quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [IDX_W-1:0]  idx_ff, idx_in, idx_next;
   logic [LUMA_W-1:0] ref_ff, ref_in;
   logic              have_ref_ff, have_ref_in;
   logic              fin_ff, fin_in;
   logic              stop;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  border_ff, border_in;
   logic              accepted_ff, accepted_in;
   logic [EXT_W-1:0]  ext;
   logic              out_free;

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.border   = border_ff;
   assign rsp.accepted = accepted_ff;

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      s_in         = s_ff;
      q_in         = q_ff;
      nq_in        = nq_ff;
      ss_in        = ss_ff;
      tn_in        = tn_ff;
      rn_in        = rn_ff;
      ts_in        = ts_ff;
      tn2_in       = tn2_ff;
      dm_in        = dm_ff;
      noisy_in     = noisy_ff;
      far_in       = far_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      ref_in       = ref_ff;
      have_ref_in  = have_ref_ff;
      fin_in       = fin_ff;
      border_in    = border_ff;
      accepted_in  = accepted_ff;
      q_pop        = 1'b0;
      stop         = 1'b0;
      idx_next     = idx_ff;
      out_free     = !rsp_valid_ff || rsp.ready;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      ext          = (cfg.scan_extent > EXT_W'(EXTENT_MAX)) ? EXT_W'(EXTENT_MAX)
                                                            : cfg.scan_extent;
      diff         = (rn_ff >= RN_W'(s_ff)) ? rn_ff - RN_W'(s_ff) : RN_W'(s_ff) - rn_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               n_in  = q_rec.n;
               s_in  = q_rec.s;
               q_in  = q_rec.q;
               if (q_rec.start) begin
                  idx_in      = '0;
                  ref_in      = '0;
                  have_ref_in = 1'b0;
                  fin_in      = 1'b0;
               end
               if (q_rec.has_line && (q_rec.start || !fin_ff)) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            nq_in    = NQ_W'(n_ff) * NQ_W'(q_ff);
            ss_in    = SS_W'(s_ff) * SS_W'(s_ff);
            tn_in    = TN_W'(cfg.tolerance) * TN_W'(n_ff);
            rn_in    = RN_W'(ref_ff) * RN_W'(n_ff);
            ts_in    = TS_W'(cfg.tolerance) * TS_W'(s_ff);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            tn2_in   = TN2_W'(tn_ff) * TN2_W'(tn_ff);
            dm_in    = DM_W'(diff) * DM_W'(500);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            noisy_in = NZ_W'(nq_ff) > (NZ_W'(ss_ff) + NZ_W'(tn2_ff));
            far_in   = FAR_W'(dm_ff) > {ts_ff, 2'b00};
            rem_in   = s_ff;
            dvs_in   = DIV_W'({n_ff, {(LUMA_W-1){1'b0}}});
            quo_in   = '0;
            step_in  = STEP_W'(LUMA_W - 1);
            state_in = have_ref_ff ? ST_DEC : ST_DIV;
         end
         ST_DIV: begin
            // one quotient bit per cycle, restoring
            if (rem_ff >= dvs_ff) begin
               rem_in = rem_ff - dvs_ff;
               quo_in = {quo_ff[LUMA_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[LUMA_W-2:0], 1'b0};
            end
            dvs_in  = dvs_ff >> 1;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            if (!have_ref_ff) begin
               ref_in      = quo_ff;
               have_ref_in = 1'b1;
               stop        = noisy_ff && cfg.noisy_reference_stops;
            end else begin
               stop        = far_ff || noisy_ff;
            end
            if (!stop) begin
               idx_next = idx_ff + IDX_W'(1);
               stop     = ({1'b0, idx_next} << 1) >= (IDX_W+1)'(ext);
            end
            idx_in = idx_next;
            if (stop) begin
               fin_in   = 1'b1;
               state_in = ST_OUT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               border_in    = idx_ff;
               accepted_in  = (ACC_W'(idx_ff) * ACC_W'(5)) < (ACC_W'(ext) << 1);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      s_ff      <= s_in;
      q_ff      <= q_in;
      nq_ff     <= nq_in;
      ss_ff     <= ss_in;
      tn_ff     <= tn_in;
      rn_ff     <= rn_in;
      ts_ff     <= ts_in;
      tn2_ff    <= tn2_in;
      dm_ff     <= dm_in;
      noisy_ff  <= noisy_in;
      far_ff    <= far_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      quo_ff    <= quo_in;
      step_ff   <= step_in;
      border_ff <= border_in;
      accepted_ff <= accepted_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         ref_ff       <= '0;
         have_ref_ff  <= 1'b0;
         fin_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         ref_ff       <= ref_in;
         have_ref_ff  <= have_ref_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> src/letterbox_border_detector_unit.sv
// ----------------------------------------------------------------------------
// Letterbox border detector
// Measures the uniform border at one picture edge from line statistics.
// ----------------------------------------------------------------------------
// Throughput: one pixel word per cycle while the line queue is not full. The
//   evaluator takes one line record at a time through multiply, scale, compare,
//   the mean divider on a scan's first measured line and decide; a scan-ending
//   line's result word follows, later while the 4-deep queue holds earlier lines.
// Reset: synchronous; clears queue, scan state and registers to defaults,
//   scan idle until a scan start word.
module letterbox_border_detector_unit import lbd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   lbd_req_if.sink               req_chan,
   lbd_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type       cfg_ff, cfg_in;
   line_push_type push;
   logic          q_full, q_pop, q_valid;
   line_rec_type  q_rec;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TOLERANCE:   cfg_in.tolerance             = csr_wdata[TOL_W-1:0];
            CSR_SCAN_EXTENT: cfg_in.scan_extent           = csr_wdata[EXT_W-1:0];
            CSR_NOISY_REF:   cfg_in.noisy_reference_stops = csr_wdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tolerance             <= TOL_RESET;
         cfg_ff.scan_extent           <= EXT_RESET;
         cfg_ff.noisy_reference_stops <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lbd_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .q_full (q_full),
      .push   (push)
   );

   lbd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .pop   (q_pop),
      .valid (q_valid),
      .rec   (q_rec)
   );

   lbd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (q_valid),
      .q_rec   (q_rec),
      .q_pop   (q_pop),
      .rsp     (rsp_chan)
   );

endmodule

>>> src/lbd_checker.sv
// ----------------------------------------------------------------------------
// Letterbox border detector port checker
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
module lbd_checker import lbd_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [IDX_W-1:0] rsp_border,
   input logic             rsp_accepted
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_border) && $stable(rsp_accepted))
      else $error("result word changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word valid right after reset");

   a_border_half: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_border <= IDX_W'(EXTENT_MAX / 2))
      else $error("border beyond half the largest extent");

   a_accept_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_border <= IDX_W'((2 * EXTENT_MAX - 1) / 5))
      else $error("accepted border not below 40 percent of largest extent");

endmodule

bind letterbox_border_detector_unit lbd_checker u_lbd_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_border   (rsp_chan.border),
   .rsp_accepted (rsp_chan.accepted)
);
